// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL; empty when building for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check prop on every rising clock edge outside reset.
`define IDWL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Check that expr is never true outside reset.
`define IDWL_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);
`else
`define IDWL_ASSERT(label, clk, rst_n, prop, msg)
`define IDWL_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// File: rtl/idwl_pkg.sv
`default_nettype none
package idwl_pkg;

  localparam int unsigned ID_W          = 32;
  localparam int unsigned ENTRY_COUNT_W = 9;
  localparam logic [ID_W-1:0] LAST_ID_RESET = 32'h0000_FFFF;
  localparam logic [ID_W-1:0] ID_ZERO       = 32'h0000_0000;

  typedef struct packed {
    logic [ID_W-1:0] card_id;
    logic            enroll_mode;
  } in_t;

  typedef struct packed {
    logic                     granted;
    logic                     enrolled;
    logic                     table_full;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_DECIDE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic start;   // latch the input beat, restart the scan
    logic rd_en;   // read the entry at the scan index, advance it
    logic commit;  // decide, append if due, load the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic count_zero;  // table empty
    logic last_idx;    // scan index points at the last stored entry
    logic out_free;    // output register empty or being taken
  } dp_sts_t;

endpackage
`default_nettype wire

// File: rtl/idwl_ram.sv
`default_nettype none
module idwl_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: rtl/idwl_ctrl.sv
`default_nettype none
module idwl_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire idwl_pkg::dp_sts_t sts_i,
  output idwl_pkg::dp_cmd_t     cmd_o
);

  idwl_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= idwl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    case (state_q)
      idwl_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = sts_i.count_zero ? idwl_pkg::ST_DECIDE : idwl_pkg::ST_SCAN;
        end
      end
      idwl_pkg::ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (sts_i.last_idx) begin
          state_d = idwl_pkg::ST_WAIT;
        end
      end
      idwl_pkg::ST_WAIT: begin
        // last read data is compared in this cycle
        state_d = idwl_pkg::ST_DECIDE;
      end
      idwl_pkg::ST_DECIDE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = idwl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = idwl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/idwl_dp.sv
`default_nettype none
module idwl_dp #(
  parameter int unsigned CAPACITY = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire idwl_pkg::dp_cmd_t cmd_i,
  output idwl_pkg::dp_sts_t      sts_o,
  input  wire idwl_pkg::in_t     in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output idwl_pkg::out_t         out_data_o
);

  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [idwl_pkg::ID_W-1:0] id_q;
  logic                      enroll_q;
  logic [idwl_pkg::ID_W-1:0] last_q;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [ADDR_W-1:0]         idx_q;
  logic                      rd_valid_q;
  logic                      found_q;
  logic                      out_valid_q;
  idwl_pkg::out_t            out_q;

  logic [idwl_pkg::ID_W-1:0] rdata;
  logic                      is_full;
  logic                      do_append;
  logic                      enroll_now;
  logic                      full_now;
  logic [CNT_W+idwl_pkg::ENTRY_COUNT_W-1:0] count_ext;

  idwl_ram #(
    .WIDTH (idwl_pkg::ID_W),
    .DEPTH (CAPACITY),
    .ADDR_W(ADDR_W)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (cmd_i.commit && enroll_now),
    .waddr_i(count_q[ADDR_W-1:0]),
    .wdata_i(id_q),
    .re_i   (cmd_i.rd_en),
    .raddr_i(idx_q),
    .rdata_o(rdata)
  );

  assign is_full    = (count_q == CNT_W'(CAPACITY));
  assign do_append  = enroll_q && !found_q && (id_q == last_q);
  assign full_now   = do_append && is_full;
  assign enroll_now = do_append && !is_full;
  assign count_d    = count_q + CNT_W'(enroll_now);
  assign count_ext  = {{idwl_pkg::ENTRY_COUNT_W{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= idwl_pkg::LAST_ID_RESET;
      count_q     <= '0;
      idx_q       <= '0;
      rd_valid_q  <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.rd_en;
      if (cmd_i.start) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.rd_en) begin
          idx_q <= idx_q + ADDR_W'(1);
        end
        if (rd_valid_q && (rdata == id_q)) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
        if (enroll_q) begin
          last_q <= id_q;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      id_q     <= in_data_i.card_id;
      enroll_q <= in_data_i.enroll_mode;
    end
    if (cmd_i.commit) begin
      out_q.granted     <= found_q && (id_q != idwl_pkg::ID_ZERO);
      out_q.enrolled    <= enroll_now;
      out_q.table_full  <= full_now;
      out_q.entry_count <= count_ext[idwl_pkg::ENTRY_COUNT_W-1:0];
    end
  end

  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.last_idx   = (CNT_W'(idx_q) == (count_q - CNT_W'(1)));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// File: rtl/id_whitelist_match_enroll.sv
// Card-id whitelist with enrollment.
// Input channel (in_valid_i / in_ready_o / in_data_i): one beat is one card read,
// the 32-bit card id plus the enroll-mode level.
// Output channel (out_valid_o / out_ready_i / out_data_o): exactly one beat per
// input beat: granted, enrolled, table_full and the entry count after the read.
// The block works on one read at a time. After the accept the stored ids are
// scanned one per cycle through the single read port of the id table RAM, then
// a drain step compares the last read from the RAM read register and a decide
// step appends and loads the result; an empty table skips the scan and the
// drain. A new read is accepted only once the last one has been decided.
// Only entries below the count are read, so the table needs no clearing pass;
// reset empties it at once by clearing the count and sets the last enroll id
// to 0x0000FFFF.
// A result waits in the output register until taken; the next read is
// accepted and scanned meanwhile, and holds in its decide step while the
// receiver stalls.
`default_nettype none
`include "assert_macros.svh"
module id_whitelist_match_enroll #(
  parameter int unsigned CAPACITY = 256
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire idwl_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output idwl_pkg::out_t      out_data_o
);

  idwl_pkg::dp_cmd_t cmd;
  idwl_pkg::dp_sts_t sts;

  // sequencer: accept, scan, drain, decide
  idwl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // table, count, compare and output register
  idwl_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // a refused append never also counts as enrolled
  `IDWL_ASSERT_NEVER(a_enroll_xor_full, clk_i, rst_ni,
                     out_valid_o && out_data_o.enrolled && out_data_o.table_full,
                     "enrolled and table_full both set")
  // a result is loaded only when the output register can take it
  `IDWL_ASSERT(a_commit_free, clk_i, rst_ni, cmd.commit |-> sts.out_free,
               "result loaded over a pending beat")
  // no scan read on an empty table
  `IDWL_ASSERT(a_scan_nonempty, clk_i, rst_ni, cmd.rd_en |-> !sts.count_zero,
               "scan read with empty table")
  // the block is not ready again in the cycle after an accept
  `IDWL_ASSERT(a_busy_after_accept, clk_i, rst_ni,
               (in_valid_i && in_ready_o) |=> !in_ready_o,
               "input accepted back to back")

endmodule
`default_nettype wire
